[design/ins_pkg.sv]
// Shared constants and types for the insertion sorter.
package ins_pkg;

	localparam int DEPTH = 64;
	localparam int VAL_W = 8;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic shift;
		val_t value;
	} cell_ctrl_t;

endpackage

[design/ins_cell.sv]
// One compare-and-shift cell of the sorting chain.
module ins_cell
	import ins_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occ,
	input  logic       left_occ,
	input  logic       left_gt,
	input  val_t       left_data,
	input  val_t       right_data,
	output logic       gt,
	output val_t       data
);

	val_t data_q;
	logic take;

	// The cell holds a value strictly greater than the one being inserted.
	assign gt   = occ && (data_q > ctrl.value);
	// Cells from the insertion point on move right; the first empty cell fills.
	assign take = gt || (!occ && left_occ);
	assign data = data_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert && take) begin
			data_q <= left_gt ? left_data : ctrl.value;
		end else if (ctrl.shift) begin
			data_q <= right_data;
		end
	end

endmodule

[design/ins_ctrl.sv]
// Load and drain sequencer of the insertion sorter, with fill count and drop flag.
module ins_ctrl
	import ins_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	input  logic out_ready,
	output logic in_ready,
	output logic out_valid,
	output logic out_last,
	output logic out_overflow,
	output logic do_insert,
	output logic do_shift,
	output cnt_t count
);

	state_t state_q, state_d;
	cnt_t   count_q;
	logic   drop_q;
	logic   full;
	logic   in_fire;
	logic   out_fire;
	logic   final_one;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign final_one = (count_q == CNT_W'(1));
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_fire && in_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_fire && final_one) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_LOAD: in_ready  = 1'b1;
			ST_EMIT: out_valid = 1'b1;
			default: begin
				in_ready  = 1'b0;
				out_valid = 1'b0;
			end
		endcase
	end

	assign do_insert    = in_fire && !full;
	assign do_shift     = out_fire;
	assign out_last     = final_one;
	assign out_overflow = drop_q;
	assign count        = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_shift) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (in_fire && full) begin
				drop_q <= 1'b1;
			end else if (out_fire && final_one) begin
				drop_q <= 1'b0;
			end
		end
	end

endmodule

[design/insertion_sorter.sv]
// Top level of the stable ascending insertion sorter built from a chain of cells.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata = value, s_tlast = last
//  m_*     | out | m_tvalid/m_tready  | m_tdata = sorted_value, m_tlast = last_res,
//          |     |                    | m_tuser = overflow
//
// Loading takes one item per cycle: every cell compares its value with the new
// one in parallel and the cells past the insertion point move one place right.
// After the item marked last, the chain drains from cell 0 at one result per
// cycle while m_tready is high, shifting left on each taken result; no input is
// taken while draining. Reset clears the fill count, the drop flag and the
// sequencer; the cell values need no reset because only occupied cells are
// ever read. A stalled result simply holds the chain, since cell 0 is the
// output register.
module insertion_sorter
	import ins_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [VAL_W-1:0] s_tdata,   // [7:0] value
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [VAL_W-1:0] m_tdata,   // [7:0] sorted_value
	output logic             m_tlast,
	output logic             m_tuser    // [0] overflow
);

	cell_ctrl_t ctrl;
	logic       do_insert;
	logic       do_shift;
	cnt_t       count;

	// Per-cell occupancy, comparison flags and stored values along the chain.
	logic [DEPTH-1:0] occ;
	logic [DEPTH-1:0] gt;
	val_t             data [DEPTH];

	ins_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_last      (s_tlast),
		.out_ready    (m_tready),
		.in_ready     (s_tready),
		.out_valid    (m_tvalid),
		.out_last     (m_tlast),
		.out_overflow (m_tuser),
		.do_insert    (do_insert),
		.do_shift     (do_shift),
		.count        (count)
	);

	assign ctrl.insert = do_insert;
	assign ctrl.shift  = do_shift;
	assign ctrl.value  = s_tdata;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			// The occupied cells are always the first count cells of the chain.
			assign occ[i] = (count > CNT_W'(i));

			if (i == 0) begin : g_head
				// The head cell has an occupied, never-greater neighbor on its left.
				ins_cell u_cell (
					.clk        (clk),
					.ctrl       (ctrl),
					.occ        (occ[i]),
					.left_occ   (1'b1),
					.left_gt    (1'b0),
					.left_data  (s_tdata),
					.right_data (data[i+1]),
					.gt         (gt[i]),
					.data       (data[i])
				);
			end else if (i == DEPTH - 1) begin : g_tail
				// The tail cell keeps its value on a shift; it is empty by then.
				ins_cell u_cell (
					.clk        (clk),
					.ctrl       (ctrl),
					.occ        (occ[i]),
					.left_occ   (occ[i-1]),
					.left_gt    (gt[i-1]),
					.left_data  (data[i-1]),
					.right_data (data[i]),
					.gt         (gt[i]),
					.data       (data[i])
				);
			end else begin : g_mid
				ins_cell u_cell (
					.clk        (clk),
					.ctrl       (ctrl),
					.occ        (occ[i]),
					.left_occ   (occ[i-1]),
					.left_gt    (gt[i-1]),
					.left_data  (data[i-1]),
					.right_data (data[i+1]),
					.gt         (gt[i]),
					.data       (data[i])
				);
			end
		end
	endgenerate

	// Cell 0 always holds the smallest remaining value during the drain.
	assign m_tdata = data[0];

endmodule
